// ===== sv/sha256_pkg.sv =====
`default_nettype none
package sha256_pkg;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

endpackage
`default_nettype wire

// ===== sv/sha256_ram.sv =====
`default_nettype none
module sha256_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/sha256_stream_hasher_top.sv =====
`default_nettype none
// Channel  | Signals                                           | Direction
// input    | in_valid_i/in_ready_o, message_byte_i, has_byte_i, | in
//          | end_of_message_i                                  |
// output   | out_valid_o/out_ready_i, digest_word_o,            | out
//          | word_index_o, last_word_o                         |
//
// A byte without end of message is written straight into the buffer, and the
// item that fills a block adds one compression. A compression loads the block
// one buffer byte per cycle through the single RAM read port, whose read is
// registered, then runs 64 rounds through one shared round unit and folds the
// result into the hash words.
// End of message runs padding and one or two compressions, then presents
// eight digest words, one per transfer; the selected word holds while
// out_ready_i is low.
// Reset clears all control state and restores the initial hash values.
module sha256_stream_hasher_top
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  message_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        end_of_message_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] digest_word_o,
  output      logic [2:0]  word_index_o,
  output      logic        last_word_o
);

  typedef enum logic [2:0] {
    StIdle, StLoad, StRound, StFold, StPad, StOut
  } state_e;

  state_e      state_q;
  logic [5:0]  fill_q;      // bytes in the current block
  logic [63:0] bits_q;
  logic [63:0] len_q;       // bit length, latched with every accepted item
  logic        final_q;     // closing the message
  logic        last_blk_q;  // this compression is the final one
  logic        mark_q;      // the 0x80 marker has been written
  logic [6:0]  cnt_q;       // load, round, pad and output counter
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];

  // Buffer RAM. Reads are addressed by cnt_q; the read data is registered.
  logic       we;
  logic [5:0] waddr, raddr;
  logic [7:0] wdata, rdata;

  sha256_ram #(.Width(8), .Depth(64)) u_buf (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Padding byte at position fill_q + cnt during the pad sweep. The first
  // byte of the first sweep of a message is the 0x80 marker.
  logic [5:0] pad_pos;
  logic [7:0] pad_byte;
  assign pad_pos = fill_q + cnt_q[5:0];
  always_comb begin
    pad_byte = 8'h00;
    if (!mark_q)
      pad_byte = PadByte;
    else if (last_blk_q && pad_pos >= LenStart)
      pad_byte = len_q[8'(7 - (pad_pos - LenStart)) * 8 +: 8];
  end

  always_comb begin
    we    = 1'b0;
    waddr = fill_q;
    wdata = message_byte_i;
    if (state_q == StIdle && in_valid_i && has_byte_i) begin
      we = 1'b1;
    end else if (state_q == StIdle && in_valid_i && end_of_message_i) begin
      we = 1'b0;
    end else if (state_q == StPad) begin
      we    = 1'b1;
      waddr = pad_pos;
      wdata = pad_byte;
    end
  end
  assign raddr = cnt_q[5:0];

  // Shared round unit.
  logic [31:0] wt, ls0, ls1, x, y, s0, s1, ch, maj, t1, t2;
  logic [3:0]  ti;
  assign ti  = cnt_q[3:0];
  assign x   = w_q[4'(ti + 4'd1)];
  assign y   = w_q[4'(ti + 4'd14)];
  assign ls0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  assign ls1 = {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
  assign wt  = (cnt_q >= 7'd16) ? w_q[ti] + ls0 + w_q[4'(ti + 4'd9)] + ls1
                                : w_q[ti];
  assign s1  = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
             ^ {v_q[4][24:0], v_q[4][31:25]};
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1  = v_q[7] + s1 + ch + RoundK[cnt_q[5:0]] + wt;
  assign s0  = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
             ^ {v_q[0][21:0], v_q[0][31:22]};
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2  = s0 + maj;

  assign in_ready_o    = (state_q == StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = h_q[cnt_q[2:0]];
  assign word_index_o  = cnt_q[2:0];
  assign last_word_o   = (cnt_q[2:0] == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      fill_q     <= '0;
      bits_q     <= '0;
      len_q      <= '0;
      final_q    <= 1'b0;
      last_blk_q <= 1'b0;
      mark_q     <= 1'b0;
      cnt_q      <= '0;
      h_q        <= InitHash;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            logic [63:0] nb;
            logic [6:0]  nf;
            nb = bits_q + (has_byte_i ? 64'd8 : 64'd0);
            nf = {1'b0, fill_q} + (has_byte_i ? 7'd1 : 7'd0);
            bits_q  <= nb;
            fill_q  <= nf[5:0];
            final_q <= end_of_message_i;
            len_q   <= nb;
            mark_q  <= 1'b0;
            cnt_q   <= '0;
            if (nf[6]) begin
              last_blk_q <= 1'b0;
              state_q    <= StLoad;
            end else if (end_of_message_i) begin
              // Pad byte goes at nf; then zeros (and length if it fits).
              last_blk_q <= (nf[5:0] < LenStart);
              state_q    <= StPad;
            end
          end
        end
        StPad: begin
          // The first cycle of a message's first sweep writes the 0x80 marker.
          mark_q <= 1'b1;
          if (pad_pos == 6'd63) begin
            cnt_q   <= '0;
            state_q <= StLoad;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        StLoad: begin
          if (cnt_q == 7'd64) begin
            cnt_q   <= '0;
            state_q <= StRound;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        StRound: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd63) state_q <= StFold;
        end
        StFold: begin
          cnt_q <= '0;
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          fill_q <= '0;
          if (!final_q) begin
            state_q <= StIdle;
          end else if (!last_blk_q) begin
            // Either the full block before padding or the first of two.
            last_blk_q <= 1'b1;
            state_q    <= StPad;
          end else begin
            state_q <= StOut;
          end
        end
        StOut: begin
          if (out_ready_i) begin
            if (cnt_q[2:0] == 3'd7) begin
              h_q     <= InitHash;
              bits_q  <= '0;
              fill_q  <= '0;
              final_q <= 1'b0;
              cnt_q   <= '0;
              state_q <= StIdle;
            end else begin
              cnt_q <= cnt_q + 7'd1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Schedule window and working variables carry no reset. Each byte shifts
  // into the newest word, and the window moves on as each word begins.
  always_ff @(posedge clk_i) begin
    if (state_q == StLoad && cnt_q != 7'd0) begin
      if (cnt_q[1:0] == 2'd1) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      end
      w_q[15] <= {w_q[15][23:0], rdata};
    end
    if (state_q == StLoad && cnt_q == 7'd64) begin
      v_q <= h_q;
    end
    if (state_q == StRound) begin
      w_q[ti] <= wt;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while emitting");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_word_o) |-> (word_index_o == 3'd7))
    else $error("last word index");
  a_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o) |=> in_ready_o)
    else $error("not idle after digest");
`endif

endmodule
`default_nettype wire

// ===== sim/sha256_stream_hasher_top_test.sv =====
module sha256_stream_hasher_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sha256_pkg::*;

  // Golden SHA-256 engine plus the queue of digest words still owed by the block.
  class digest_scoreboard;
    logic [31:0] hash_q [8];
    logic [7:0]  block_buf [64];
    int unsigned fill;
    logic [63:0] bit_count;
    logic [31:0] word_q [$];
    logic [2:0]  index_q [$];
    logic        last_q [$];
    int unsigned mismatches;

    function new();
      hash_q = InitHash;
      fill = 0;
      bit_count = '0;
      mismatches = 0;
    endfunction

    function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] x, y, t1, t2, s0, s1, ch, maj;
      for (int i = 0; i < 16; i++)
        w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
      v = hash_q;
      for (int t = 0; t < 64; t++) begin
        if (t >= 16) begin
          x = w[(t + 1) % 16];
          y = w[(t + 14) % 16];
          w[t % 16] = w[t % 16] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[(t + 9) % 16]
                      + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
        end
        s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1 = v[7] + s1 + ch + RoundK[t] + w[t % 16];
        s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
        maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2 = s0 + maj;
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_q[i] += v[i];
    endfunction

    // Called once per accepted input transfer.
    function void note_input(logic [7:0] b, logic hb, logic eom);
      logic [63:0] len;
      if (hb) begin
        block_buf[fill] = b;
        fill++;
        bit_count += 64'd8;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!eom) return;
      len = bit_count;
      block_buf[fill] = PadByte;
      fill++;
      if (fill > 56) begin
        for (int i = fill; i < 64; i++) block_buf[i] = 8'h00;
        compress();
        fill = 0;
      end
      for (int i = fill; i < 56; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_buf[63 - i] = len[8*i +: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        word_q = {word_q, hash_q[i]};
        index_q = {index_q, 3'(i)};
        last_q = {last_q, (i == 7)};
      end
      hash_q = InitHash;
      fill = 0;
      bit_count = '0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_word(logic [31:0] w, logic [2:0] idx, logic lst);
      if (word_q.size() == 0) begin
        report($sformatf("unexpected digest word %h", w));
        return;
      end
      if (w !== word_q[0]) report($sformatf("digest_word %h, wanted %h", w, word_q[0]));
      if (idx !== index_q[0]) report($sformatf("word_index %0d, wanted %0d", idx, index_q[0]));
      if (lst !== last_q[0]) report($sformatf("last_word %b, wanted %b", lst, last_q[0]));
      void'(word_q.pop_front());
      void'(index_q.pop_front());
      void'(last_q.pop_front());
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  message_byte_i = '0;
  logic        has_byte_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_stream_hasher_top dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  digest_scoreboard sb = new();
  bit   stim_done = 1'b0;
  bit   quiet_tail = 1'b0;     // Set for the last part of the run: no idling at all.
  bit   hold_sink = 1'b0;      // The sender asks the receiver for one long hold-off.
  int unsigned cycle_count = 0;

  // Sample both handshakes at the rising edge; the scoreboard sees the transfer there.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_input(message_byte_i, has_byte_i, end_of_message_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(digest_word_o, word_index_o, last_word_o);
  end

  // Drive one item at the falling edge, hold it until the transfer, maybe idle afterward.
  task automatic send_item(logic [7:0] b, logic hb, logic eom);
    in_valid_i       <= 1'b1;
    message_byte_i   <= b;
    has_byte_i       <= hb;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  // A message of len random bytes, or an empty message when len is zero.
  task automatic send_message(int unsigned len);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1));
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.word_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        out_ready_i <= 1'b0;
        repeat (600) @(negedge clk_i);
        hold_sink = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned len;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty message, idle items, byte extremes, padding corners.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'ha5, 1'b0, 1'b0);
    send_item(8'h5a, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1);
    send_message(56);   // Length spills into a second final compression.
    send_message(64);   // Exactly one full block before the padding block.
    wait_drained();

    // Pressure: the receiver holds off while several short messages wait behind the first digest.
    hold_sink = 1'b1;
    for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3));
    wait_drained();

    // Random part: short messages with some idle noise, and none in the last messages.
    for (int m = 0; m < 12; m++) begin
      if (m == 8) quiet_tail = 1'b1;
      len = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_message(len);
    end

    wait_drained();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (400) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.word_q.size() == 0)
      $display("PASS sha256_stream_hasher_top");
    else
      $display("FAIL sha256_stream_hasher_top");
    $finish;
  end

  initial begin
    wait (cycle_count == 500000);
    $display("FAIL sha256_stream_hasher_top");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sha256_pkg.sv
sv/sha256_ram.sv
sv/sha256_stream_hasher_top.sv
sim/sha256_stream_hasher_top_test.sv
